[rtl/dsms_pkg.sv]
// Shared types and constants for the differential step move sequencer.
// No dependencies; every file of the block but dsms_queue imports this package.
package dsms_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [3:0] CMD_TICK         = 4'd0;
  localparam logic [3:0] CMD_FORWARD      = 4'd1;
  localparam logic [3:0] CMD_BACKWARD     = 4'd2;
  localparam logic [3:0] CMD_TURN_LEFT    = 4'd3;
  localparam logic [3:0] CMD_TURN_RIGHT   = 4'd4;
  localparam logic [3:0] CMD_PEN_UP       = 4'd5;
  localparam logic [3:0] CMD_PEN_DOWN     = 4'd6;
  localparam logic [3:0] CMD_ESTOP        = 4'd7;
  localparam logic [3:0] CMD_CLEAR        = 4'd8;
  localparam logic [3:0] CMD_RESET_TOTALS = 4'd9;

  // Configuration register indexes.
  localparam logic REG_PEN_UP   = 1'b0;
  localparam logic REG_PEN_DOWN = 1'b1;

  // Reset values of the angle registers and the servo range limit.
  localparam logic [7:0] PEN_UP_RESET   = 8'd90;
  localparam logic [7:0] PEN_DOWN_RESET = 8'd0;
  localparam logic [7:0] ANGLE_MAX      = 8'd180;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_MOVING = 2'd1;
  localparam logic [1:0] MODE_ERROR  = 2'd2;
  localparam logic [1:0] MODE_ESTOP  = 2'd3;

  // Motion state machine.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MOVING = 4'b0010,
    ST_ERROR  = 4'b0100,
    ST_ESTOP  = 4'b1000
  } mode_state_t;

  // Step pulse codes.
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BWD  = 2'd2
  } step_t;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NOP          = 3'd0,
    OP_TICK         = 3'd1,
    OP_MOVE         = 3'd2,
    OP_PEN_UP       = 3'd3,
    OP_PEN_DOWN     = 3'd4,
    OP_ESTOP        = 3'd5,
    OP_CLEAR        = 3'd6,
    OP_RESET_TOTALS = 3'd7
  } op_t;

  typedef struct packed {
    op_t  op;
    logic left_neg;
    logic right_neg;
    logic left_ready;
    logic right_ready;
  } front_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  mode;
    logic        pen_lowered;
    logic [7:0]  servo_angle;
    logic [1:0]  left_step;
    logic [1:0]  right_step;
    logic        release_motors;
    logic        move_done;
    logic [31:0] left_total;
    logic [31:0] right_total;
  } result_t;

  function automatic logic [1:0] mode_code(input mode_state_t s);
    logic [1:0] c;
    case (s)
      ST_IDLE:   c = MODE_IDLE;
      ST_MOVING: c = MODE_MOVING;
      ST_ERROR:  c = MODE_ERROR;
      ST_ESTOP:  c = MODE_ESTOP;
      default:   c = MODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    return (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

endpackage

[rtl/dsms_queue.sv]
// Small first-in first-out queue built from a register array.
// Used between the front and back ends and on the result side; no package use.
module dsms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/dsms_front.sv]
// Front end: decodes each command into an operation and queues it.
// Depends on dsms_pkg and dsms_queue.
module dsms_front
  import dsms_pkg::*;
#(
  parameter int STEP_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [3:0]           in_command,
  input  logic [STEP_BITS-1:0] in_steps,
  input  logic                 in_left_ready,
  input  logic                 in_right_ready,
  output front_item_t          q_item,
  output logic [STEP_BITS-1:0] q_steps,
  output logic                 q_valid,
  input  logic                 q_pop
);

  localparam int IW = $bits(front_item_t);
  localparam int QW = IW + STEP_BITS;

  front_item_t   item;
  logic          steps_pos;
  logic          q_empty;
  logic [QW-1:0] q_rdata;

  // A move with a step count of zero or below is dropped here: it behaves
  // exactly like an unused command.
  assign steps_pos = ~in_steps[STEP_BITS-1] & (|in_steps);

  always_comb begin
    item.op          = OP_NOP;
    item.left_neg    = 1'b0;
    item.right_neg   = 1'b0;
    item.left_ready  = in_left_ready;
    item.right_ready = in_right_ready;
    case (in_command)
      CMD_TICK:         item.op = OP_TICK;
      CMD_FORWARD: begin
        if (steps_pos) begin
          item.op = OP_MOVE;
        end
      end
      CMD_BACKWARD: begin
        if (steps_pos) begin
          item.op        = OP_MOVE;
          item.left_neg  = 1'b1;
          item.right_neg = 1'b1;
        end
      end
      CMD_TURN_LEFT: begin
        if (steps_pos) begin
          item.op       = OP_MOVE;
          item.left_neg = 1'b1;
        end
      end
      CMD_TURN_RIGHT: begin
        if (steps_pos) begin
          item.op        = OP_MOVE;
          item.right_neg = 1'b1;
        end
      end
      CMD_PEN_UP:       item.op = OP_PEN_UP;
      CMD_PEN_DOWN:     item.op = OP_PEN_DOWN;
      CMD_ESTOP:        item.op = OP_ESTOP;
      CMD_CLEAR:        item.op = OP_CLEAR;
      CMD_RESET_TOTALS: item.op = OP_RESET_TOTALS;
      default:          item.op = OP_NOP;
    endcase
  end

  dsms_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .wdata ({item, in_steps}),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign q_valid = ~q_empty;
  assign q_item  = front_item_t'(q_rdata[QW-1:STEP_BITS]);
  assign q_steps = q_rdata[STEP_BITS-1:0];

endmodule

[rtl/dsms_back.sv]
// Back end: motion state, step generation, running totals and result queue.
// Depends on dsms_pkg and dsms_queue.
module dsms_back
  import dsms_pkg::*;
#(
  parameter int STEP_BITS  = 16,
  parameter int TOTAL_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  front_item_t          q_item,
  input  logic [STEP_BITS-1:0] q_steps,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [7:0]           pen_up_angle,
  input  logic [7:0]           pen_down_angle,
  output logic                 res_empty,
  input  logic                 res_pop,
  output result_t              res
);

  localparam int PB = STEP_BITS + 1;
  localparam int RW = $bits(result_t);

  mode_state_t            mode_r, mode_nxt;
  logic                   pen_r, pen_nxt;
  logic                   active_r, active_nxt;
  logic signed [PB-1:0]   ltgt_r, ltgt_nxt, rtgt_r, rtgt_nxt;
  logic signed [PB-1:0]   lpos_r, lpos_nxt, rpos_r, rpos_nxt;
  logic [TOTAL_BITS-1:0]  lsum_r, lsum_nxt, rsum_r, rsum_nxt;
  logic [7:0]             angle_r, angle_nxt;

  logic signed [PB-1:0]   mag;
  step_t                  lstep, rstep;
  logic                   accepted, release_w, done_w;
  logic                   exec, res_full;
  logic signed [63:0]     lext, rext;
  result_t                res_w;
  logic [RW-1:0]          res_rdata;

  function automatic step_t step_dir(input logic signed [PB-1:0] tgt,
                                     input logic signed [PB-1:0] pos,
                                     input logic rdy);
    step_t d;
    d = STEP_NONE;
    if (pos != tgt && rdy) begin
      if (!tgt[PB-1] && (tgt != '0)) begin
        if (pos < tgt) begin
          d = STEP_FWD;
        end
      end else if (pos > tgt) begin
        d = STEP_BWD;
      end
    end
    return d;
  endfunction

  assign exec  = q_valid & ~res_full;
  assign q_pop = exec;
  assign mag   = {1'b0, q_steps};

  always_comb begin
    mode_nxt   = mode_r;
    pen_nxt    = pen_r;
    active_nxt = active_r;
    ltgt_nxt   = ltgt_r;
    rtgt_nxt   = rtgt_r;
    lpos_nxt   = lpos_r;
    rpos_nxt   = rpos_r;
    lsum_nxt   = lsum_r;
    rsum_nxt   = rsum_r;
    angle_nxt  = angle_r;
    lstep      = STEP_NONE;
    rstep      = STEP_NONE;
    accepted   = 1'b0;
    release_w  = 1'b0;
    done_w     = 1'b0;
    case (q_item.op)
      OP_TICK: begin
        if (active_r && mode_r == ST_MOVING) begin
          lstep = step_dir(ltgt_r, lpos_r, q_item.left_ready);
          rstep = step_dir(rtgt_r, rpos_r, q_item.right_ready);
          if (lstep == STEP_FWD) begin
            lpos_nxt = lpos_r + PB'(1);
            lsum_nxt = lsum_r + TOTAL_BITS'(1);
          end else if (lstep == STEP_BWD) begin
            lpos_nxt = lpos_r - PB'(1);
            lsum_nxt = lsum_r - TOTAL_BITS'(1);
          end
          if (rstep == STEP_FWD) begin
            rpos_nxt = rpos_r + PB'(1);
            rsum_nxt = rsum_r + TOTAL_BITS'(1);
          end else if (rstep == STEP_BWD) begin
            rpos_nxt = rpos_r - PB'(1);
            rsum_nxt = rsum_r - TOTAL_BITS'(1);
          end
          if (lpos_nxt == ltgt_r && rpos_nxt == rtgt_r) begin
            active_nxt = 1'b0;
            mode_nxt   = ST_IDLE;
            done_w     = 1'b1;
          end
        end
      end
      OP_MOVE: begin
        if (mode_r == ST_IDLE) begin
          ltgt_nxt   = q_item.left_neg ? -mag : mag;
          rtgt_nxt   = q_item.right_neg ? -mag : mag;
          lpos_nxt   = '0;
          rpos_nxt   = '0;
          active_nxt = 1'b1;
          mode_nxt   = ST_MOVING;
          accepted   = 1'b1;
        end
      end
      OP_PEN_UP: begin
        angle_nxt = clamp_angle(pen_up_angle);
        pen_nxt   = 1'b0;
      end
      OP_PEN_DOWN: begin
        angle_nxt = clamp_angle(pen_down_angle);
        pen_nxt   = 1'b1;
      end
      OP_ESTOP: begin
        release_w  = 1'b1;
        active_nxt = 1'b0;
        mode_nxt   = ST_ESTOP;
      end
      OP_CLEAR: begin
        if (mode_r inside {ST_ERROR, ST_ESTOP}) begin
          release_w  = 1'b1;
          active_nxt = 1'b0;
          mode_nxt   = ST_IDLE;
        end
      end
      OP_RESET_TOTALS: begin
        lsum_nxt = '0;
        rsum_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Totals are reported as 32-bit signed values, sign extended or cut down.
  assign lext = 64'(signed'(lsum_nxt));
  assign rext = 64'(signed'(rsum_nxt));

  always_comb begin
    res_w.accepted       = accepted;
    res_w.mode           = mode_code(mode_nxt);
    res_w.pen_lowered    = pen_nxt;
    res_w.servo_angle    = angle_nxt;
    res_w.left_step      = lstep;
    res_w.right_step     = rstep;
    res_w.release_motors = release_w;
    res_w.move_done      = done_w;
    res_w.left_total     = lext[31:0];
    res_w.right_total    = rext[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ST_IDLE;
      pen_r    <= 1'b0;
      active_r <= 1'b0;
      ltgt_r   <= '0;
      rtgt_r   <= '0;
      lpos_r   <= '0;
      rpos_r   <= '0;
      lsum_r   <= '0;
      rsum_r   <= '0;
      angle_r  <= PEN_UP_RESET;
    end else if (exec) begin
      mode_r   <= mode_nxt;
      pen_r    <= pen_nxt;
      active_r <= active_nxt;
      ltgt_r   <= ltgt_nxt;
      rtgt_r   <= rtgt_nxt;
      lpos_r   <= lpos_nxt;
      rpos_r   <= rpos_nxt;
      lsum_r   <= lsum_nxt;
      rsum_r   <= rsum_nxt;
      angle_r  <= angle_nxt;
    end
  end

  dsms_queue #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (exec),
    .full  (res_full),
    .wdata (res_w),
    .pop   (res_pop),
    .empty (res_empty),
    .rdata (res_rdata)
  );

  assign res = result_t'(res_rdata);

  // The motion flag and the moving state must never disagree.
  a_active_mode: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == (mode_r == ST_MOVING))
    else $error("motion flag and moving state disagree");

  // Step pulses come only from a tick taken while moving.
  a_step_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (lstep != STEP_NONE || rstep != STEP_NONE))
      |-> (q_item.op == OP_TICK && mode_r == ST_MOVING))
    else $error("step pulse outside a moving tick");

  // A completed move leaves the block idle with the motion flag down.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && done_w) |=> (mode_r == ST_IDLE && !active_r))
    else $error("move completion did not return to idle");

  // While moving, the left position stays between zero and its target.
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ST_MOVING) |->
      (ltgt_r[PB-1] ? (lpos_r >= ltgt_r && lpos_r <= 0)
                    : (lpos_r <= ltgt_r && lpos_r >= 0)))
    else $error("left position overran its target");

endmodule

[rtl/differential_step_move_sequencer_core.sv]
// A command taken into the front queue is executed by the back end; its result
// goes into the result queue and shows on the out_ ports. Throughput is one command
// per cycle while the result queue has room, set by the back end's execute step.
// Both sides are short queues (two entries each), so the block keeps accepting
// while results wait. Reset (rst_n low at a clock edge) empties both queues, sets
// idle mode, pen up, zero totals, servo angle 90 and the angle registers to 90 / 0.
module differential_step_move_sequencer_core
  import dsms_pkg::*;
#(
  parameter int STEP_BITS  = 16,
  parameter int TOTAL_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  // Command channel.
  input  logic                 push,
  output logic                 full,
  input  logic [3:0]           in_command,
  input  logic [STEP_BITS-1:0] in_steps,
  input  logic                 in_left_ready,
  input  logic                 in_right_ready,
  // Result channel.
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_accepted,
  output logic [1:0]           out_mode,
  output logic                 out_pen_lowered,
  output logic [7:0]           out_servo_angle,
  output logic [1:0]           out_left_step,
  output logic [1:0]           out_right_step,
  output logic                 out_release_motors,
  output logic                 out_move_done,
  output logic signed [31:0]   out_left_total,
  output logic signed [31:0]   out_right_total
);

  // Pen angle registers. They are sampled by the back end only when a pen
  // command executes, so a new value shows up at the next pen command.
  logic [7:0] pen_up_angle_r;
  logic [7:0] pen_down_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_up_angle_r   <= PEN_UP_RESET;
      pen_down_angle_r <= PEN_DOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEN_UP:   pen_up_angle_r   <= cfg_data;
        REG_PEN_DOWN: pen_down_angle_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes each command into an operation; moves with a step
  // count of zero or less become no-ops right there. The decoded operation
  // waits in a two-entry queue until the back end takes it.
  front_item_t          q_item;
  logic [STEP_BITS-1:0] q_steps;
  logic                 q_valid;
  logic                 q_pop;
  result_t              res;

  dsms_front #(
    .STEP_BITS (STEP_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_steps       (in_steps),
    .in_left_ready  (in_left_ready),
    .in_right_ready (in_right_ready),
    .q_item         (q_item),
    .q_steps        (q_steps),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  // The back end holds the motion state. It executes one operation per cycle
  // whenever its result queue has room, and every operation produces exactly
  // one result item in that queue.
  dsms_back #(
    .STEP_BITS  (STEP_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (q_item),
    .q_steps        (q_steps),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .pen_up_angle   (pen_up_angle_r),
    .pen_down_angle (pen_down_angle_r),
    .res_empty      (empty),
    .res_pop        (pop),
    .res            (res)
  );

  assign out_accepted       = res.accepted;
  assign out_mode           = res.mode;
  assign out_pen_lowered    = res.pen_lowered;
  assign out_servo_angle    = res.servo_angle;
  assign out_left_step      = res.left_step;
  assign out_right_step     = res.right_step;
  assign out_release_motors = res.release_motors;
  assign out_move_done      = res.move_done;
  assign out_left_total     = res.left_total;
  assign out_right_total    = res.right_total;

endmodule

[bench/tb_motion_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the step move sequencer bench: it predicts one result per command.
// Depends on dsms_pkg for the command, mode, step codes and the result layout.
package tb_motion_pkg;
  import dsms_pkg::*;

  class motion_scoreboard;
    // Angle registers as last written, and the predicted motion state.
    logic [7:0]         up_angle;
    logic [7:0]         down_angle;
    logic [1:0]         mode;
    bit                 pen_down;
    bit                 active;
    logic signed [16:0] l_goal, r_goal, l_pos, r_pos;
    logic [31:0]        l_sum, r_sum;
    logic [7:0]         angle;

    result_t pending_results[$];
    int errors, commands, effective, moves_started, moves_done, checked;

    function new();
      up_angle   = PEN_UP_RESET;
      down_angle = PEN_DOWN_RESET;
      mode       = MODE_IDLE;
      pen_down   = 0;
      active     = 0;
      l_goal = '0; r_goal = '0; l_pos = '0; r_pos = '0;
      l_sum  = '0; r_sum  = '0;
      angle  = PEN_UP_RESET;
    endfunction

    function void set_angle(logic index, logic [7:0] value);
      if (index == REG_PEN_UP) up_angle = value;
      else down_angle = value;
    endfunction

    function bit moving();
      return mode == MODE_MOVING;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // One motor moves one step toward its goal when it is ready.
    function logic [1:0] advance(input logic signed [16:0] goal, inout logic signed [16:0] pos,
                                 inout logic [31:0] total, input bit ready);
      if (pos == goal || !ready) return STEP_NONE;
      if (goal > 0) begin
        if (pos < goal) begin
          pos   = pos + 17'sd1;
          total = total + 32'd1;
          return STEP_FWD;
        end
      end else if (pos > goal) begin
        pos   = pos - 17'sd1;
        total = total - 32'd1;
        return STEP_BWD;
      end
      return STEP_NONE;
    endfunction

    function void note_command(logic [3:0] cmd, logic signed [15:0] steps, bit lr, bit rr);
      result_t            r;
      logic signed [16:0] wide;
      r    = '0;
      wide = steps;
      commands++;
      case (cmd)
        CMD_TICK: begin
          if (active && mode == MODE_MOVING) begin
            r.left_step  = advance(l_goal, l_pos, l_sum, lr);
            r.right_step = advance(r_goal, r_pos, r_sum, rr);
            if (l_pos == l_goal && r_pos == r_goal) begin
              active = 0;
              mode   = MODE_IDLE;
              r.move_done = 1'b1;
              moves_done++;
            end
            effective++;
          end
        end
        CMD_FORWARD, CMD_BACKWARD, CMD_TURN_LEFT, CMD_TURN_RIGHT: begin
          if (mode == MODE_IDLE && steps > 0) begin
            l_goal = (cmd == CMD_FORWARD || cmd == CMD_TURN_RIGHT) ? wide : -wide;
            r_goal = (cmd == CMD_FORWARD || cmd == CMD_TURN_LEFT) ? wide : -wide;
            l_pos  = '0;
            r_pos  = '0;
            active = 1;
            mode   = MODE_MOVING;
            r.accepted = 1'b1;
            moves_started++;
            effective++;
          end
        end
        CMD_PEN_UP: begin
          angle    = (up_angle > ANGLE_MAX) ? ANGLE_MAX : up_angle;
          pen_down = 0;
          effective++;
        end
        CMD_PEN_DOWN: begin
          angle    = (down_angle > ANGLE_MAX) ? ANGLE_MAX : down_angle;
          pen_down = 1;
          effective++;
        end
        CMD_ESTOP: begin
          r.release_motors = 1'b1;
          active = 0;
          mode   = MODE_ESTOP;
          effective++;
        end
        CMD_CLEAR: begin
          if (mode == MODE_ERROR || mode == MODE_ESTOP) begin
            r.release_motors = 1'b1;
            active = 0;
            mode   = MODE_IDLE;
            effective++;
          end
        end
        CMD_RESET_TOTALS: begin
          l_sum = '0;
          r_sum = '0;
          effective++;
        end
        default: ;
      endcase
      r.mode        = mode;
      r.pen_lowered = pen_down;
      r.servo_angle = angle;
      r.left_total  = l_sum;
      r.right_total = r_sum;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no command outstanding, got %p", $time, got);
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      compare_field("accepted", 32'(exp.accepted), 32'(got.accepted));
      compare_field("mode", 32'(exp.mode), 32'(got.mode));
      compare_field("pen_lowered", 32'(exp.pen_lowered), 32'(got.pen_lowered));
      compare_field("servo_angle", 32'(exp.servo_angle), 32'(got.servo_angle));
      compare_field("left_step", 32'(exp.left_step), 32'(got.left_step));
      compare_field("right_step", 32'(exp.right_step), 32'(got.right_step));
      compare_field("release_motors", 32'(exp.release_motors), 32'(got.release_motors));
      compare_field("move_done", 32'(exp.move_done), 32'(got.move_done));
      compare_field("left_total", exp.left_total, got.left_total);
      compare_field("right_total", exp.right_total, got.right_total);
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top-level bench for differential_step_move_sequencer_core: stimulus, result
// monitor and watchdog. Depends on dsms_pkg and on the scoreboard in tb_motion_pkg.
module tb_top;
  import dsms_pkg::*;
  import tb_motion_pkg::*;

  // If no transfer happens on either side for this many cycles, the run is hung.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  in_command = '0;
  logic [15:0] in_steps = '0;
  logic        in_left_ready = 1'b0;
  logic        in_right_ready = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_accepted;
  logic [1:0]  out_mode;
  logic        out_pen_lowered;
  logic [7:0]  out_servo_angle;
  logic [1:0]  out_left_step;
  logic [1:0]  out_right_step;
  logic        out_release_motors;
  logic        out_move_done;
  logic signed [31:0] out_left_total;
  logic signed [31:0] out_right_total;

  // When clear, neither side inserts idle cycles, so transfers run back to back.
  bit gaps_on = 1'b1;
  int phases_run = 0;

  motion_scoreboard sb = new();

  differential_step_move_sequencer_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .in_command         (in_command),
    .in_steps           (in_steps),
    .in_left_ready      (in_left_ready),
    .in_right_ready     (in_right_ready),
    .empty              (empty),
    .pop                (pop),
    .out_accepted       (out_accepted),
    .out_mode           (out_mode),
    .out_pen_lowered    (out_pen_lowered),
    .out_servo_angle    (out_servo_angle),
    .out_left_step      (out_left_step),
    .out_right_step     (out_right_step),
    .out_release_motors (out_release_motors),
    .out_move_done      (out_move_done),
    .out_left_total     (out_left_total),
    .out_right_total    (out_right_total)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sends one command. All drives happen right after a rising edge, and the
  // transfer is taken at the first later edge where full was low. Push is left
  // high on return, so a following command can go out in the very next cycle
  // without push being lowered and raised in one time step.
  task automatic send_command(logic [3:0] cmd, logic [15:0] steps, bit lr, bit rr);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_command     <= cmd;
    in_steps       <= steps;
    in_left_ready  <= lr;
    in_right_ready <= rr;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_command(cmd, steps, lr, rr);
  endtask

  // Motors report ready three times out of four, so a move sees some stalls.
  function automatic bit mostly_ready();
    return $urandom_range(0, 3) != 0;
  endfunction

  // Stops driving commands and waits until every predicted result has been
  // taken. Each command yields exactly one result, so an empty scoreboard means
  // the block holds nothing.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes both angle registers on back-to-back cycles while the block is idle.
  task automatic write_angles(logic [7:0] up, logic [7:0] down);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PEN_UP;
    cfg_data  <= up;
    @(posedge clk);
    cfg_index <= REG_PEN_DOWN;
    cfg_data  <= down;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_angle(REG_PEN_UP, up);
    sb.set_angle(REG_PEN_DOWN, down);
  endtask

  // Corner cases first, with the angle registers at their reset values.
  task automatic run_directed();
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);          // tick with nothing to move
    send_command(CMD_PEN_DOWN, 16'h0000, 1'b0, 1'b0);
    send_command(CMD_PEN_UP, 16'hFFFF, 1'b1, 1'b1);
    send_command(CMD_FORWARD, 16'h0000, 1'b1, 1'b1);       // zero steps are rejected
    send_command(CMD_BACKWARD, 16'hFFFF, 1'b1, 1'b1);      // negative steps too
    send_command(CMD_TURN_LEFT, 16'h8000, 1'b1, 1'b1);     // most negative count
    send_command(CMD_CLEAR, 16'h0000, 1'b0, 1'b0);         // clear while idle does nothing
    send_command(4'd15, 16'h5A5A, 1'b1, 1'b1);             // unused code
    send_command(CMD_FORWARD, 16'd2, 1'b0, 1'b0);
    send_command(CMD_TURN_RIGHT, 16'd5, 1'b1, 1'b1);       // move while busy is ignored
    send_command(CMD_TICK, 16'hA5A5, 1'b0, 1'b1);
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);          // completes the move
    send_command(CMD_BACKWARD, 16'd1, 1'b0, 1'b0);
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);
    send_command(CMD_TURN_LEFT, 16'd1, 1'b0, 1'b0);
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);
    send_command(CMD_TURN_RIGHT, 16'h7FFF, 1'b0, 1'b0);    // largest legal count
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);
    send_command(CMD_ESTOP, 16'h0000, 1'b0, 1'b0);
    send_command(CMD_FORWARD, 16'd3, 1'b1, 1'b1);          // ignored in emergency stop
    send_command(CMD_CLEAR, 16'h0000, 1'b0, 1'b0);
    send_command(CMD_RESET_TOTALS, 16'h0000, 1'b0, 1'b0);
    send_command(4'd10, 16'h1234, 1'b0, 1'b1);
    send_command(CMD_TICK, 16'h0000, 1'b1, 1'b1);
  endtask

  // A well-formed move: optional pen change, a move, then ticks until it ends.
  // Now and then a stray command lands in the middle. Long moves are cut short
  // by an emergency stop and a clear so that the run stays short.
  task automatic move_sequence();
    logic [3:0] op;
    int         n;
    int         ticks;
    op = CMD_FORWARD + 4'($urandom_range(0, 3));
    n  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 32767) : $urandom_range(1, 12);
    if ($urandom_range(0, 2) == 0)
      send_command($urandom_range(0, 1) ? CMD_PEN_UP : CMD_PEN_DOWN, 16'($urandom), 1'b0, 1'b0);
    send_command(op, 16'(n), 1'($urandom), 1'($urandom));
    ticks = 0;
    while (sb.moving() && ticks < 40) begin
      if ($urandom_range(0, 9) == 0)
        send_command(4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      else
        send_command(CMD_TICK, 16'($urandom), mostly_ready(), mostly_ready());
      ticks++;
    end
    if (sb.moving()) begin
      send_command(CMD_ESTOP, 16'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 1) == 0)
        send_command(op, 16'($urandom_range(1, 32767)), 1'b1, 1'b1);
      send_command(CMD_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Random traffic, mostly complete moves, until the phase has sent its share
  // of commands.
  task automatic run_random(int budget);
    int start;
    int pick;
    start = sb.commands;
    while (sb.commands - start < budget) begin
      if ($urandom_range(0, 39) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        move_sequence();
      end else if (pick < 72) begin
        send_command($urandom_range(0, 1) ? CMD_PEN_UP : CMD_PEN_DOWN, 16'($urandom),
                     1'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        send_command(CMD_ESTOP, 16'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 0)
          send_command(CMD_BACKWARD, 16'($urandom_range(1, 32767)), 1'b1, 1'b1);
        if ($urandom_range(0, 3) != 0)
          send_command(CMD_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 86) begin
        send_command(CMD_RESET_TOTALS, 16'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_command(4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    phases_run++;
  endtask

  // Result side: pop with random stalls and take a result at every edge where
  // pop was high and empty was low. Pop also stays high across back-to-back
  // transfers, so it gets at most one assignment per time step.
  initial begin
    int      stall;
    result_t got;
    @(posedge rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      got.accepted       = out_accepted;
      got.mode           = out_mode;
      got.pen_lowered    = out_pen_lowered;
      got.servo_angle    = out_servo_angle;
      got.left_step      = out_left_step;
      got.right_step     = out_right_step;
      got.release_motors = out_release_motors;
      got.move_done      = out_move_done;
      got.left_total     = out_left_total;
      got.right_total    = out_right_total;
      sb.check_result(got);
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("differential_step_move_sequencer_core regression: fail");
    $finish;
  end

  // Main sequence: reset once, directed checks and a first random phase at the
  // reset angles, then further random phases, each under a new pair of pen angles.
  // The pairs cover both ends of the legal range and values above it, which must saturate.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(RANDOM_PER_PHASE / 4);
    drain();
    write_angles(8'd0, 8'd180);
    run_random(RANDOM_PER_PHASE);
    drain();
    write_angles(8'd180, 8'd0);
    run_random(RANDOM_PER_PHASE);
    drain();
    write_angles(8'd255, 8'd181);
    run_random(RANDOM_PER_PHASE);
    drain();
    write_angles(8'($urandom), 8'($urandom));
    run_random(RANDOM_PER_PHASE);
    drain();
    write_angles(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)));
    run_random(RANDOM_PER_PHASE);
    drain();

    $display("Sent %0d commands over %0d random phases; %0d changed state, %0d results checked.",
             sb.commands, phases_run, sb.effective, sb.checked);
    $display("Moves started %0d, completed %0d; angle pairs reached 0, 180 and above range.",
             sb.moves_started, sb.moves_done);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("differential_step_move_sequencer_core regression: pass");
    else
      $display("differential_step_move_sequencer_core regression: fail");
    $finish;
  end

endmodule
